/* design/grp_pkg.sv */
// ----------------------------------------------------------------------------
// grp_pkg
// Shared types and constants for the guillotine rectangle packer.
// ----------------------------------------------------------------------------
package grp_pkg;

   localparam int MAX_AREAS = 64;
   localparam int IDX_W     = $clog2(MAX_AREAS);
   localparam int CNT_W     = $clog2(MAX_AREAS + 1);
   localparam int FIELD_W   = 15;
   localparam int ENTRY_W   = 4 * FIELD_W;
   localparam int CSR_ADDR_W = 8;

   localparam logic [CSR_ADDR_W-1:0] REG_ATLAS_WIDTH  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_ATLAS_HEIGHT = CSR_ADDR_W'(1);

   localparam logic [FIELD_W-1:0] ATLAS_SIZE_RESET = FIELD_W'(4096);

   typedef enum logic [1:0] {
      STATUS_PLACED = 2'd0,
      STATUS_NO_FIT = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE,
      ST_RIGHT,
      ST_BELOW,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] left;
      logic [FIELD_W-1:0] top;
      logic [FIELD_W-1:0] w;
      logic [FIELD_W-1:0] h;
   } area_type;

endpackage

/* design/grp_ifs.sv */
// ----------------------------------------------------------------------------
// grp_ifs
// Channel interfaces for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface grp_req_if import grp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] rect_width;
   logic [FIELD_W-1:0] rect_height;

   modport source (output valid, output rect_width, output rect_height, input ready);
   modport sink   (input valid, input rect_width, input rect_height, output ready);
endinterface

interface grp_rsp_if import grp_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [FIELD_W-1:0] place_x;
   logic [FIELD_W-1:0] place_y;

   modport source (output valid, output status, output place_x, output place_y,
                   input ready);
   modport sink   (input valid, input status, input place_x, input place_y,
                   output ready);
endinterface

interface grp_csr_if import grp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [FIELD_W-1:0]    data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

/* design/guillotine_rect_packer.sv */
// ----------------------------------------------------------------------------
// guillotine_rect_packer
// First-fit guillotine placement of rectangles in a 2-D atlas.
//
// A request transaction carries rect_width and rect_height. Each request
// yields exactly one response transaction with status, place_x and place_y.
// The atlas size is written through the register channel, which is always
// ready; writes are expected only while the block is idle.
// The free areas are held in one RAM with a registered read. The first-fit
// search streams one entry per cycle through that read port. A full list
// answers once a fitting entry is found and a miss once the whole list is
// scanned. The next request is taken in the cycle in which the response
// appears.
// A new request is taken while an earlier response still waits; the
// block stalls before writing the next response until the first is taken.
// Reset clears the list length and the seeded flag and restores the atlas
// size to 4096 by 4096; the first request seeds the list with the whole atlas.
// ----------------------------------------------------------------------------
module guillotine_rect_packer import grp_pkg::*; (
   input logic         clock,
   input logic         reset,
   grp_req_if.sink     req_if,
   grp_rsp_if.source   rsp_if,
   grp_csr_if.sink     csr_if
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               seeded_ff, seeded_in;
   logic [FIELD_W-1:0] atlas_w_ff, atlas_w_in;
   logic [FIELD_W-1:0] atlas_h_ff, atlas_h_in;
   logic [FIELD_W-1:0] rw_ff, rw_in;
   logic [FIELD_W-1:0] rh_ff, rh_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   area_type           hit_ff, hit_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0] rsp_x_ff, rsp_x_in;
   logic [FIELD_W-1:0] rsp_y_ff, rsp_y_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   area_type           wr_entry;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   area_type           rd_entry;
   logic               fit;
   logic [CNT_W-1:0]   last_idx;
   logic               req_fire;

   grp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_AREAS)
   ) u_area_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = area_type'(rd_data);
   assign last_idx = count_ff - CNT_W'(1);
   assign fit      = cmp_vld_ff && (rw_ff <= rd_entry.w) && (rh_ff <= rd_entry.h);
   assign rd_addr  = (state_ff == ST_SCAN && !fit) ? scan_ff[IDX_W-1:0]
                                                   : last_idx[IDX_W-1:0];

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.status  = rsp_status_ff;
   assign rsp_if.place_x = rsp_x_ff;
   assign rsp_if.place_y = rsp_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         seeded_ff    <= 1'b0;
         atlas_w_ff   <= ATLAS_SIZE_RESET;
         atlas_h_ff   <= ATLAS_SIZE_RESET;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         seeded_ff    <= seeded_in;
         atlas_w_ff   <= atlas_w_in;
         atlas_h_ff   <= atlas_h_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rw_ff         <= rw_in;
      rh_ff         <= rh_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_ff        <= hit_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

   always_comb begin
      atlas_w_in = atlas_w_ff;
      atlas_h_in = atlas_h_ff;
      if (csr_if.valid) begin
         unique case (csr_if.addr)
            REG_ATLAS_WIDTH:  atlas_w_in = csr_if.data;
            REG_ATLAS_HEIGHT: atlas_h_in = csr_if.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      seeded_in     = seeded_ff;
      rw_in         = rw_ff;
      rh_in         = rh_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      hit_idx_in    = hit_idx_ff;
      hit_in        = hit_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_entry      = area_type'(rd_data);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rw_in      = req_if.rect_width;
               rh_in      = req_if.rect_height;
               scan_in    = '0;
               cmp_vld_in = 1'b0;
               state_in   = ST_SCAN;
               if (!seeded_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = '0;
                  wr_entry.left = '0;
                  wr_entry.top  = '0;
                  wr_entry.w    = atlas_w_ff;
                  wr_entry.h    = atlas_h_ff;
                  count_in      = CNT_W'(1);
                  seeded_in     = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (fit) begin
               hit_in     = rd_entry;
               hit_idx_in = cmp_idx_ff;
               cmp_vld_in = 1'b0;
               if (count_ff == CNT_W'(MAX_AREAS)) begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_MOVE;
               end
            end else if (cmp_vld_ff && ({1'b0, cmp_idx_ff} == CNT_W'(last_idx))) begin
               cmp_vld_in    = 1'b0;
               res_status_in = STATUS_NO_FIT;
               state_in      = ST_DONE;
            end else begin
               cmp_vld_in = (scan_ff < count_ff);
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end
         end
         ST_MOVE: begin
            wr_en    = 1'b1;
            wr_addr  = hit_idx_ff;
            wr_entry = rd_entry;
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            wr_en         = 1'b1;
            wr_addr       = last_idx[IDX_W-1:0];
            wr_entry.left = FIELD_W'(hit_ff.left + rw_ff);
            wr_entry.top  = hit_ff.top;
            wr_entry.w    = FIELD_W'(hit_ff.w - rw_ff);
            wr_entry.h    = rh_ff;
            state_in      = ST_BELOW;
         end
         ST_BELOW: begin
            wr_en         = 1'b1;
            wr_addr       = count_ff[IDX_W-1:0];
            wr_entry.left = hit_ff.left;
            wr_entry.top  = FIELD_W'(hit_ff.top + rh_ff);
            wr_entry.w    = hit_ff.w;
            wr_entry.h    = FIELD_W'(hit_ff.h - rh_ff);
            count_in      = count_ff + CNT_W'(1);
            res_status_in = STATUS_PLACED;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_x_in      = (res_status_ff == STATUS_PLACED) ? hit_ff.left : '0;
               rsp_y_in      = (res_status_ff == STATUS_PLACED) ? hit_ff.top : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_AREAS))
      else $error("free list length exceeds its capacity");

   a_scan_seeded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (seeded_ff && count_ff != '0))
      else $error("search running on an unseeded or empty list");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BELOW) |-> (count_ff < CNT_W'(MAX_AREAS)))
      else $error("append beyond the end of the free list");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_PLACED) |->
         (rsp_x_ff == '0 && rsp_y_ff == '0))
      else $error("failed placement carries a nonzero position");

   a_list_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BELOW) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("placement did not grow the free list by one");

endmodule

/* design/grp_ram.sv */
// ----------------------------------------------------------------------------
// grp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module grp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
